### design/lpnt_pkg.sv
// shared constants, codes and control structs of the linear probe node table
`timescale 1ns / 1ps
package lpnt_pkg;

	localparam int unsigned TABLE_ENTRIES_DEF = 16384;

	localparam int unsigned KEY_W    = 64;
	localparam int unsigned FOLD_W   = 32;
	localparam int unsigned PLY_W    = 10;
	localparam int unsigned CMD_W    = 2;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned SLOT_W   = 14;
	localparam int unsigned USED_W   = 15;
	localparam int unsigned THR_W    = 10;
	localparam int unsigned PADDR_W  = 5;
	localparam int unsigned PDATA_W  = 64;

	localparam int unsigned PERMILLE      = 1000;
	localparam logic [THR_W-1:0] THR_RESET = THR_W'(800);

	// request codes
	localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

	// result codes
	localparam logic [STATUS_W-1:0] ST_HIT       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_MISS      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd4;

	// register indexes (byte address 8*i)
	localparam logic [1:0] REG_SIDE_KEY_FIRST  = 2'd0;
	localparam logic [1:0] REG_SIDE_KEY_SECOND = 2'd1;
	localparam logic [1:0] REG_FULL_THRESHOLD  = 2'd2;

	typedef struct packed {
		logic             used;
		logic [KEY_W-1:0] position_key;
		logic [KEY_W-1:0] hand_hash;
		logic             side;
		logic [PLY_W-1:0] ply;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

	// controller to datapath
	typedef struct packed {
		logic                capture;
		logic                zero_count;
		logic                probe_rd;
		logic                step;
		logic                insert;
		logic                clr_wr;
		logic                set_res;
		logic                res_sel_idx;
		logic [STATUS_W-1:0] res_status;
		logic                load_out;
	} lpnt_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic req_insert;
		logic used;
		logic match;
		logic wrap;
		logic clr_last;
		logic out_free;
	} lpnt_stat_t;

endpackage

### design/lpnt_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module lpnt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### design/lpnt_ctrl.sv
// controller state machine: clear sweep, probe loop and result handoff
`timescale 1ns / 1ps
module lpnt_ctrl
	import lpnt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [CMD_W-1:0] in_cmd,
	output logic             in_ready,
	input  lpnt_stat_t       stat,
	output lpnt_cmd_t        cmd
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_CMP,
		S_RESULT
	} state_t;

	state_t state_q, state_nxt;
	logic   from_req_q, from_req_nxt;
	logic   ready_q;
	logic   accept;

	assign in_ready = ready_q;
	assign accept   = in_valid & ready_q;

	always_comb begin
		cmd          = '0;
		state_nxt    = state_q;
		from_req_nxt = from_req_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (stat.clr_last) begin
					if (from_req_q) begin
						cmd.set_res    = 1'b1;
						cmd.res_status = ST_CLEARED;
						state_nxt      = S_RESULT;
					end else begin
						state_nxt = S_IDLE;
					end
				end
			end
			S_IDLE: begin
				if (accept) begin
					cmd.capture = 1'b1;
					if (in_cmd == CMD_CLEAR) begin
						cmd.zero_count = 1'b1;
						from_req_nxt   = 1'b1;
						state_nxt      = S_CLEAR;
					end else begin
						state_nxt = S_READ;
					end
				end
			end
			S_READ: begin
				cmd.probe_rd = 1'b1;
				state_nxt    = S_CMP;
			end
			S_CMP: begin
				if (!stat.used) begin
					cmd.set_res = 1'b1;
					if (stat.req_insert) begin
						cmd.insert      = 1'b1;
						cmd.res_sel_idx = 1'b1;
						cmd.res_status  = ST_INSERTED;
					end else begin
						cmd.res_status = ST_MISS;
					end
					state_nxt = S_RESULT;
				end else if (stat.match) begin
					cmd.set_res     = 1'b1;
					cmd.res_sel_idx = 1'b1;
					cmd.res_status  = ST_HIT;
					state_nxt       = S_RESULT;
				end else if (stat.wrap) begin
					cmd.set_res    = 1'b1;
					cmd.res_status = ST_EXHAUSTED;
					state_nxt      = S_RESULT;
				end else begin
					cmd.step  = 1'b1;
					state_nxt = S_READ;
				end
			end
			S_RESULT: begin
				// wait for room in the output register
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			from_req_q <= 1'b0;
			ready_q    <= 1'b0;
		end else begin
			state_q    <= state_nxt;
			from_req_q <= (state_nxt == S_CLEAR) ? from_req_nxt : 1'b0;
			ready_q    <= (state_nxt == S_IDLE);
		end
	end

endmodule

### design/lpnt_dpath.sv
// datapath: config registers, hash, probe index, entry store, count and result
`timescale 1ns / 1ps
module lpnt_dpath
	import lpnt_pkg::*;
#(
	parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// request payload
	input  logic [CMD_W-1:0]    cmd,
	input  logic [KEY_W-1:0]    position_key,
	input  logic [KEY_W-1:0]    hand_hash,
	input  logic                side,
	input  logic [PLY_W-1:0]    ply,
	// result channel
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status,
	output logic [SLOT_W-1:0]   slot,
	output logic [USED_W-1:0]   entries_used,
	output logic                table_full,
	// config port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready,
	// control
	input  lpnt_cmd_t           ctl,
	output lpnt_stat_t          stat
);

	localparam int unsigned IDX_W  = $clog2(TABLE_ENTRIES);
	localparam int unsigned CNT_W  = IDX_W + 1;
	localparam int unsigned PROD_W = CNT_W + THR_W;
	localparam int unsigned SWID_W = IDX_W + SLOT_W;
	localparam int unsigned UWID_W = CNT_W + USED_W;

	function automatic logic [FOLD_W-1:0] fold64(input logic [KEY_W-1:0] v);
		return v[FOLD_W-1:0] ^ v[KEY_W-1:FOLD_W];
	endfunction

	// config registers
	logic [KEY_W-1:0] side_key_first_q;
	logic [KEY_W-1:0] side_key_second_q;
	logic [THR_W-1:0] threshold_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_key_first_q  <= '0;
			side_key_second_q <= '0;
			threshold_q       <= THR_RESET;
		end else if (cfg_wr) begin
			case (paddr[4:3])
				REG_SIDE_KEY_FIRST:  side_key_first_q  <= pwdata;
				REG_SIDE_KEY_SECOND: side_key_second_q <= pwdata;
				REG_FULL_THRESHOLD:  threshold_q       <= pwdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:3])
			REG_SIDE_KEY_FIRST:  prdata = side_key_first_q;
			REG_SIDE_KEY_SECOND: prdata = side_key_second_q;
			REG_FULL_THRESHOLD:  prdata = PDATA_W'(threshold_q);
			default:             prdata = '0;
		endcase
	end

	// home slot
	logic [KEY_W-1:0]  side_key;
	logic [FOLD_W-1:0] hash;

	assign side_key = side ? side_key_second_q : side_key_first_q;
	assign hash     = fold64(position_key) ^ fold64(hand_hash) ^ fold64(side_key)
	                  ^ FOLD_W'(ply);

	// request registers
	logic [KEY_W-1:0] pos_q;
	logic [KEY_W-1:0] hand_q;
	logic             side_q;
	logic [PLY_W-1:0] ply_q;
	logic             insert_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] start_q;
	logic [IDX_W-1:0] idx_nxt;

	assign idx_nxt = idx_q + 1'b1;

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			pos_q    <= position_key;
			hand_q   <= hand_hash;
			side_q   <= side;
			ply_q    <= ply;
			insert_q <= (cmd == CMD_INSERT);
			idx_q    <= hash[IDX_W-1:0];
			start_q  <= hash[IDX_W-1:0];
		end else if (ctl.step) begin
			idx_q <= idx_nxt;
		end
	end

	// entry store
	logic [IDX_W-1:0] clr_idx_q;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	entry_t           ram_wdata;
	entry_t           new_entry;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t           rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (ctl.clr_wr) begin
			clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	assign new_entry = '{used: 1'b1, position_key: pos_q, hand_hash: hand_q,
	                     side: side_q, ply: ply_q};
	assign ram_we    = ctl.insert | ctl.clr_wr;
	assign ram_waddr = ctl.clr_wr ? clr_idx_q : idx_q;
	assign ram_wdata = ctl.clr_wr ? entry_t'('0) : new_entry;
	assign rd        = entry_t'(ram_rdata);

	lpnt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ctl.probe_rd),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	// occupancy
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.zero_count) begin
			count_q <= '0;
		end else if (ctl.insert) begin
			count_q <= count_q + 1'b1;
		end
	end

	// permille rate: count * 1000 / entries, entries a power of two
	logic [PROD_W-1:0] prod;
	logic [THR_W:0]    rate;
	logic              full;

	assign prod = PROD_W'(count_q) * PROD_W'(PERMILLE);
	assign rate = (THR_W + 1)'(prod >> IDX_W);
	assign full = rate > {1'b0, threshold_q};

	// result and output register
	logic [STATUS_W-1:0] res_status_q;
	logic [IDX_W-1:0]    res_idx_q;
	logic                out_valid_q;
	logic [SWID_W-1:0]   slot_wide;
	logic [UWID_W-1:0]   used_wide;

	always_ff @(posedge clk) begin
		if (ctl.set_res) begin
			res_status_q <= ctl.res_status;
			res_idx_q    <= ctl.res_sel_idx ? idx_q : '0;
		end
	end

	assign slot_wide = SWID_W'(res_idx_q);
	assign used_wide = UWID_W'(count_q);

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			status       <= res_status_q;
			slot         <= slot_wide[SLOT_W-1:0];
			entries_used <= used_wide[USED_W-1:0];
			table_full   <= full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// status to controller
	assign stat.req_insert = insert_q;
	assign stat.used       = rd.used;
	assign stat.match      = (rd.position_key == pos_q) && (rd.hand_hash == hand_q)
	                         && (rd.side == side_q) && (rd.ply == ply_q);
	assign stat.wrap       = (idx_nxt == start_q);
	assign stat.clr_last   = &clr_idx_q;
	assign stat.out_free   = ~out_valid_q | out_ready;

endmodule

### design/linear_probe_node_table.sv
// top level of the linear probe node table
//
// open-addressed node table keyed by position key, hand key, side and ply.
// requests arrive on the in_valid / in_ready channel with cmd: lookup,
// lookup or insert, or clear. each request gives exactly one result on the
// out_valid / out_ready channel: status, slot, entries_used and table_full.
// the side keys and the full threshold sit behind an apb-style port at byte
// addresses 0, 8 and 16; write them only while the table is idle.
// a lookup or insert loads its result once a probe decides it, starting at
// the home slot: each probe is one read of the entry ram and then a compare.
// a new request is taken the cycle after the result is loaded, while that
// result may still wait downstream, so a request is not taken until the
// last one's result is loaded.
// a clear request sweeps all TABLE_ENTRIES slots of the entry ram, one slot
// a cycle, and then returns its result.
// after reset the same sweep runs with in_ready low.
// when the receiver stalls, the result holds in the output register; a
// second finished result waits inside until that register frees.
`timescale 1ns / 1ps
module linear_probe_node_table
	import lpnt_pkg::*;
#(
	parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [CMD_W-1:0]    cmd,
	input  logic [KEY_W-1:0]    position_key,
	input  logic [KEY_W-1:0]    hand_hash,
	input  logic                side,
	input  logic [PLY_W-1:0]    ply,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status,
	output logic [SLOT_W-1:0]   slot,
	output logic [USED_W-1:0]   entries_used,
	output logic                table_full,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready
);

	lpnt_cmd_t  ctl;
	lpnt_stat_t stat;

	lpnt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_cmd  (cmd),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (ctl)
	);

	lpnt_dpath #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.position_key(position_key),
		.hand_hash   (hand_hash),
		.side        (side),
		.ply         (ply),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.slot        (slot),
		.entries_used(entries_used),
		.table_full  (table_full),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.ctl         (ctl),
		.stat        (stat)
	);

endmodule
